### rtl/scsm_pkg.sv
// shared types and constants for the sorted count stream merge combiner
package scsm_pkg;

    localparam int MAX_STREAMS = 8;
    localparam int KEY_BITS    = 64;
    localparam int COUNT_BITS  = 32;
    localparam int SID_BITS    = 3;
    localparam int SC_BITS     = 4;
    localparam int OP_BITS     = 5;
    localparam int CFG_BITS    = 64;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_OPERATION    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MATH_CONST   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STREAM_COUNT = 2'd3;

    localparam logic [OP_BITS-1:0] OP_PASS      = 5'd0;
    localparam logic [OP_BITS-1:0] OP_LT        = 5'd1;
    localparam logic [OP_BITS-1:0] OP_GT        = 5'd2;
    localparam logic [OP_BITS-1:0] OP_ATLEAST   = 5'd3;
    localparam logic [OP_BITS-1:0] OP_ATMOST    = 5'd4;
    localparam logic [OP_BITS-1:0] OP_EQ        = 5'd5;
    localparam logic [OP_BITS-1:0] OP_NE        = 5'd6;
    localparam logic [OP_BITS-1:0] OP_ADD       = 5'd7;
    localparam logic [OP_BITS-1:0] OP_SUB       = 5'd8;
    localparam logic [OP_BITS-1:0] OP_MUL       = 5'd9;
    localparam logic [OP_BITS-1:0] OP_DIV       = 5'd10;
    localparam logic [OP_BITS-1:0] OP_DIVROUND  = 5'd11;
    localparam logic [OP_BITS-1:0] OP_MOD       = 5'd12;
    localparam logic [OP_BITS-1:0] OP_UNION     = 5'd13;
    localparam logic [OP_BITS-1:0] OP_UNION_MIN = 5'd14;
    localparam logic [OP_BITS-1:0] OP_UNION_MAX = 5'd15;
    localparam logic [OP_BITS-1:0] OP_UNION_SUM = 5'd16;
    localparam logic [OP_BITS-1:0] OP_ISECT     = 5'd17;
    localparam logic [OP_BITS-1:0] OP_ISECT_MIN = 5'd18;
    localparam logic [OP_BITS-1:0] OP_ISECT_MAX = 5'd19;
    localparam logic [OP_BITS-1:0] OP_ISECT_SUM = 5'd20;
    localparam logic [OP_BITS-1:0] OP_SUBTRACT  = 5'd21;
    localparam logic [OP_BITS-1:0] OP_DIFF      = 5'd22;
    localparam logic [OP_BITS-1:0] OP_SYMDIFF   = 5'd23;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [SID_BITS-1:0]   stream_id;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
        logic                  exhausted;
    } t_in_item;

    typedef struct packed {
        logic [KEY_BITS-1:0]    out_key;
        logic [COUNT_BITS-1:0]  out_value;
        logic                   emit;
        logic [MAX_STREAMS-1:0] refill_mask;
        logic                   done_res;
    } t_out_item;

    typedef struct packed {
        logic                  start;
        logic [COUNT_BITS-1:0] dividend;
        logic [COUNT_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [COUNT_BITS-1:0] quot;
        logic [COUNT_BITS-1:0] rem;
    } t_div_rsp;

endpackage

### rtl/scsm_div.sv
// iterative restoring divider, one quotient bit per cycle
module scsm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scsm_pkg::t_div_req i_req,
    output scsm_pkg::t_div_rsp o_rsp
);
    import scsm_pkg::*;

    localparam int CW = $clog2(COUNT_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [COUNT_BITS:0]   r_rem;
    logic [COUNT_BITS-1:0] r_quo;
    logic [COUNT_BITS-1:0] r_dvs;
    logic [COUNT_BITS:0]   n_shift;
    logic                  n_ge;
    logic [COUNT_BITS:0]   n_rem;

    always_comb begin
        n_shift = {r_rem[COUNT_BITS-1:0], r_quo[COUNT_BITS-1]};
        n_ge    = n_shift >= {1'b0, r_dvs};
        n_rem   = n_ge ? (n_shift - {1'b0, r_dvs}) : n_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(COUNT_BITS);
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[COUNT_BITS-2:0], n_ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem[COUNT_BITS-1:0];

endmodule

### rtl/sorted_count_stream_merge_combiner_unit.sv
// Merges up to eight key-sorted (key, count) streams into one combined stream.
// Input channel (i_in_valid / o_in_stall) carries one request that refills the
// head of one stream; requests for streams not in use or not pending are dropped.
// Once every pending head is refilled, a merge round runs and yields one result
// on the output channel (o_out_valid / i_out_stall): smallest key, combined
// value, emit flag, refill mask, or a done result when all streams are exhausted.
// A round walks the heads one per cycle, then combines them and loads the
// output register; multiply may pass through ST_MUL and ST_MULS first, and
// divide, divround and mod may wait on one shared bit-serial divider in ST_DIV.
// o_in_stall is high while a round is being worked out. The result sits in an
// output register; the block keeps taking requests while it waits, and a
// finished round holds until the output register is free. Configuration
// writes go through i_cfg_we / i_cfg_idx / i_cfg_data; the user is to make
// them only while idle, which the block does not enforce. Writing stream_count
// restarts the merge. Reset (synchronous, active low) clears all heads, sets
// one stream in use and pending, and empties the output.
module sorted_count_stream_merge_combiner_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  scsm_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output scsm_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [scsm_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [scsm_pkg::CFG_BITS-1:0]         i_cfg_data
);
    import scsm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_CALC = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_MULS = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0] r_state;

    logic [OP_BITS-1:0]     r_op;
    logic [63:0]            r_thr;
    logic [63:0]            r_mc;
    logic [SC_BITS-1:0]     r_sc;

    logic [KEY_BITS-1:0]    r_head_key [MAX_STREAMS];
    logic [COUNT_BITS-1:0]  r_head_cnt [MAX_STREAMS];
    logic [MAX_STREAMS-1:0] r_head_vld;
    logic [MAX_STREAMS-1:0] r_pend;

    logic [SID_BITS-1:0]    r_idx;
    logic [KEY_BITS-1:0]    r_key;
    logic [SC_BITS-1:0]     r_n;
    logic [MAX_STREAMS-1:0] r_mask;
    logic [SID_BITS-1:0]    r_first;
    logic [COUNT_BITS-1:0]  r_c0;
    logic [COUNT_BITS-1:0]  r_min;
    logic [COUNT_BITS-1:0]  r_max;
    logic [COUNT_BITS-1:0]  r_sum;
    logic [COUNT_BITS-1:0]  r_sub;
    logic [COUNT_BITS-1:0]  r_val;
    logic [2*COUNT_BITS-1:0] r_prod;

    logic                   r_out_valid;
    t_out_item              r_out;

    t_div_req               div_req;
    t_div_rsp               div_rsp;

    logic                   in_acc;
    logic                   in_ok;
    logic [MAX_STREAMS-1:0] n_pend;
    logic [SC_BITS-1:0]     sc_m1;
    logic [SC_BITS-1:0]     n_sc;
    logic [KEY_BITS-1:0]    hk;
    logic [COUNT_BITS-1:0]  hc;
    logic                   hv;
    logic [COUNT_BITS:0]    sum_w;
    logic [COUNT_BITS:0]    add_w;
    logic [63:0]            c0_w;
    logic                   all_n;
    logic                   mc_hi;
    logic                   mc_zero;
    logic [COUNT_BITS-1:0]  calc_val;
    logic [COUNT_BITS-1:0]  div_val;
    logic [COUNT_BITS-1:0]  half_w;
    logic                   out_free;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign in_ok    = ({1'b0, i_in_data.stream_id} < r_sc) && r_pend[i_in_data.stream_id];
    assign n_pend   = r_pend & ~(MAX_STREAMS'(1) << i_in_data.stream_id);
    assign sc_m1    = r_sc - SC_BITS'(1);
    assign hk       = r_head_key[r_idx];
    assign hc       = r_head_cnt[r_idx];
    assign hv       = r_head_vld[r_idx];
    assign sum_w    = {1'b0, r_sum} + {1'b0, hc};
    assign c0_w     = {{(64-COUNT_BITS){1'b0}}, r_c0};
    assign all_n    = (r_n == r_sc);
    assign mc_hi    = (r_mc[63:COUNT_BITS] != '0);
    assign mc_zero  = (r_mc == '0);
    assign add_w    = {1'b0, r_c0} + {1'b0, r_mc[COUNT_BITS-1:0]};
    assign out_free = !r_out_valid || !i_out_stall;
    assign half_w   = r_mc[COUNT_BITS-1:0] - div_rsp.rem;

    always_comb begin
        if (i_cfg_data[3:0] == 4'd0) begin
            n_sc = SC_BITS'(1);
        end else if (i_cfg_data[3:0] > 4'(MAX_STREAMS)) begin
            n_sc = SC_BITS'(MAX_STREAMS);
        end else begin
            n_sc = i_cfg_data[SC_BITS-1:0];
        end
    end

    // rules settled here in ST_CALC; multiply and divide ones are finished later
    always_comb begin
        calc_val = '0;
        case (r_op)
            OP_PASS:      calc_val = r_c0;
            OP_LT:        calc_val = (c0_w <  r_thr) ? r_c0 : '0;
            OP_GT:        calc_val = (c0_w >  r_thr) ? r_c0 : '0;
            OP_ATLEAST:   calc_val = (c0_w >= r_thr) ? r_c0 : '0;
            OP_ATMOST:    calc_val = (c0_w <= r_thr) ? r_c0 : '0;
            OP_EQ:        calc_val = (c0_w == r_thr) ? r_c0 : '0;
            OP_NE:        calc_val = (c0_w != r_thr) ? r_c0 : '0;
            OP_ADD:       calc_val = (mc_hi || add_w[COUNT_BITS]) ? COUNT_MAX
                                                                  : add_w[COUNT_BITS-1:0];
            OP_SUB:       calc_val = (c0_w < r_mc) ? '0
                                     : r_c0 - r_mc[COUNT_BITS-1:0];
            OP_MUL:       calc_val = (r_c0 == '0) ? '0 : COUNT_MAX;
            OP_DIV:       calc_val = '0;
            OP_DIVROUND:  calc_val = mc_zero ? '0 : COUNT_BITS'(1);
            OP_MOD:       calc_val = mc_zero ? '0 : r_c0;
            OP_UNION:     calc_val = COUNT_BITS'(r_n);
            OP_UNION_MIN: calc_val = r_min;
            OP_UNION_MAX: calc_val = r_max;
            OP_UNION_SUM: calc_val = r_sum;
            OP_ISECT:     calc_val = all_n ? r_c0 : '0;
            OP_ISECT_MIN: calc_val = all_n ? r_min : '0;
            OP_ISECT_MAX: calc_val = all_n ? r_max : '0;
            OP_ISECT_SUM: calc_val = all_n ? r_sum : '0;
            OP_SUBTRACT:  calc_val = (r_first == '0) ? r_sub : '0;
            OP_DIFF:      calc_val = (r_n == SC_BITS'(1) && r_first == '0) ? r_c0 : '0;
            OP_SYMDIFF:   calc_val = (r_n == SC_BITS'(1)) ? r_c0 : '0;
            default:      calc_val = '0;
        endcase
    end

    always_comb begin
        if (r_op == OP_DIV) begin
            div_val = div_rsp.quot;
        end else if (r_op == OP_MOD) begin
            div_val = div_rsp.rem;
        end else if (c0_w < r_mc) begin
            div_val = COUNT_BITS'(1);
        end else begin
            div_val = div_rsp.quot + COUNT_BITS'(div_rsp.rem >= half_w);
        end
    end

    always_comb begin
        div_req.start    = (r_state == ST_CALC) && (r_n != '0) && !mc_zero && !mc_hi &&
                           (r_op == OP_DIV || r_op == OP_DIVROUND || r_op == OP_MOD);
        div_req.dividend = r_c0;
        div_req.divisor  = r_mc[COUNT_BITS-1:0];
    end

    scsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc && in_ok) begin
            r_head_key[i_in_data.stream_id] <= i_in_data.key;
            r_head_cnt[i_in_data.stream_id] <= i_in_data.count;
        end
        if (r_state == ST_MUL) begin
            r_prod <= r_c0 * r_mc[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= '0;
            r_thr       <= '0;
            r_mc        <= '0;
            r_sc        <= SC_BITS'(1);
            r_head_vld  <= '0;
            r_pend      <= MAX_STREAMS'(1);
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_n         <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_OPERATION:    r_op  <= i_cfg_data[OP_BITS-1:0];
                    CFG_THRESHOLD:    r_thr <= i_cfg_data;
                    CFG_MATH_CONST:   r_mc  <= i_cfg_data;
                    CFG_STREAM_COUNT: begin
                        r_sc       <= n_sc;
                        r_head_vld <= '0;
                        r_pend     <= MAX_STREAMS'((1 << n_sc) - 1);
                    end
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && in_ok) begin
                        r_head_vld[i_in_data.stream_id] <= !i_in_data.exhausted;
                        r_pend <= n_pend;
                        if (n_pend == '0) begin
                            r_state <= ST_SCAN;
                            r_idx   <= '0;
                            r_n     <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (hv) begin
                        if (r_n == '0 || hk < r_key) begin
                            r_key   <= hk;
                            r_c0    <= hc;
                            r_min   <= hc;
                            r_max   <= hc;
                            r_sum   <= hc;
                            r_sub   <= hc;
                            r_first <= r_idx;
                            r_n     <= SC_BITS'(1);
                            r_mask  <= MAX_STREAMS'(1) << r_idx;
                        end else if (hk == r_key) begin
                            r_n    <= r_n + SC_BITS'(1);
                            r_mask <= r_mask | (MAX_STREAMS'(1) << r_idx);
                            if (hc < r_min) r_min <= hc;
                            if (hc > r_max) r_max <= hc;
                            r_sum  <= sum_w[COUNT_BITS] ? COUNT_MAX : sum_w[COUNT_BITS-1:0];
                            r_sub  <= (r_sub > hc) ? r_sub - hc : '0;
                        end
                    end
                    r_idx <= r_idx + SID_BITS'(1);
                    if ({1'b0, r_idx} == sc_m1) begin
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    r_val <= calc_val;
                    if (r_n == '0) begin
                        r_mask  <= '0;
                        r_state <= ST_FIN;
                    end else if (div_req.start) begin
                        r_state <= ST_DIV;
                    end else if (r_op == OP_MUL && r_c0 != '0 && !mc_hi) begin
                        r_state <= ST_MUL;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_MULS;
                end
                ST_MULS: begin
                    r_val   <= (r_prod[2*COUNT_BITS-1:COUNT_BITS] != '0) ? COUNT_MAX
                                                                        : r_prod[COUNT_BITS-1:0];
                    r_state <= ST_FIN;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_val   <= div_val;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_pend      <= r_mask;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output payload, loaded with the valid flag
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            if (r_n == '0) begin
                r_out.out_key   <= '0;
                r_out.out_value <= '0;
                r_out.emit      <= 1'b0;
                r_out.done_res  <= 1'b1;
            end else begin
                r_out.out_key   <= r_key;
                r_out.out_value <= r_val;
                r_out.emit      <= (r_val != '0);
                r_out.done_res  <= 1'b0;
            end
            r_out.refill_mask <= r_mask;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/scsm_checker.sv
// port-level checks for the merge combiner, bound to the top level
module scsm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input scsm_pkg::t_out_item  o_out_data
);
    import scsm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_emit_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.emit == (o_out_data.out_value != '0)))
        else $error("emit does not track value");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |->
            o_out_data.out_value == '0 && o_out_data.refill_mask == '0 &&
            o_out_data.out_key == '0)
        else $error("done result carries data");

    a_round_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res |-> o_out_data.refill_mask != '0)
        else $error("round result with empty refill mask");

endmodule

bind sorted_count_stream_merge_combiner_unit scsm_checker u_scsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### tb/tb_sorted_count_stream_merge_combiner_unit.sv
// testbench for the sorted count stream merge combiner: random merges checked against a predictor
`timescale 1ns / 1ps

module tb_sorted_count_stream_merge_combiner_unit;
    import scsm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = 80;
    localparam logic [63:0] CMAX = 64'h0000_0000_FFFF_FFFF;

    typedef enum int {STEP_IGNORED, STEP_HELD, STEP_RESULT} t_step;

    typedef struct {
        logic [63:0] hkey[MAX_STREAMS];
        logic [63:0] hcnt[MAX_STREAMS];
        bit          hvalid[MAX_STREAMS];
        logic [7:0]  pend;
        logic [4:0]  op;
        logic [63:0] thr;
        logic [63:0] mconst;
        int          nstreams;
    } t_merge_state;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = CFG_OPERATION;
    logic [CFG_BITS-1:0] i_cfg_data = '0;

    t_merge_state gen_st, chk_st;
    t_in_item req_q[$];
    t_out_item result_q[$];
    int n_accepted = 0;
    int n_errors = 0;
    int cycles = 0;
    bit hold_sender = 1'b0;

    sorted_count_stream_merge_combiner_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    function automatic void merge_reset(inout t_merge_state s);
        for (int i = 0; i < MAX_STREAMS; i++) begin
            s.hkey[i] = '0;
            s.hcnt[i] = '0;
            s.hvalid[i] = 1'b0;
        end
        s.op = OP_PASS;
        s.thr = '0;
        s.mconst = '0;
        s.nstreams = 1;
        s.pend = 8'h01;
    endfunction

    function automatic void merge_config(inout t_merge_state s, input logic [1:0] idx,
                                         input logic [63:0] val);
        int n;
        case (idx)
            CFG_OPERATION: s.op = val[4:0];
            CFG_THRESHOLD: s.thr = val;
            CFG_MATH_CONST: s.mconst = val;
            default: begin
                n = int'(val[3:0]);
                if (n < 1) n = 1;
                if (n > MAX_STREAMS) n = MAX_STREAMS;
                s.nstreams = n;
                for (int i = 0; i < MAX_STREAMS; i++) s.hvalid[i] = 1'b0;
                s.pend = 8'((1 << n) - 1);
            end
        endcase
    endfunction

    function automatic t_step merge_step(inout t_merge_state s, input t_in_item it,
                                         output t_out_item r);
        logic [63:0] cnt[MAX_STREAMS];
        logic [63:0] key, c0, mc, v, rm;
        logic [7:0] mask;
        int sid, n, first;
        r = '0;
        sid = int'(it.stream_id);
        key = '0;
        mask = '0;
        n = 0;
        first = 0;
        v = '0;
        mc = s.mconst;
        if (sid >= s.nstreams || !s.pend[sid]) return STEP_IGNORED;
        if (it.exhausted) begin
            s.hvalid[sid] = 1'b0;
        end else begin
            s.hvalid[sid] = 1'b1;
            s.hkey[sid] = it.key;
            s.hcnt[sid] = {32'd0, it.count};
        end
        s.pend[sid] = 1'b0;
        if (s.pend != 0) return STEP_HELD;
        for (int i = 0; i < s.nstreams; i++) begin
            if (!s.hvalid[i]) continue;
            if (n == 0 || s.hkey[i] < key) begin
                key = s.hkey[i];
                cnt[0] = s.hcnt[i];
                first = i;
                n = 1;
                mask = 8'(1 << i);
            end else if (s.hkey[i] == key) begin
                cnt[n] = s.hcnt[i];
                n++;
                mask[i] = 1'b1;
            end
        end
        if (n == 0) begin
            r.done_res = 1'b1;
            return STEP_RESULT;
        end
        c0 = cnt[0];
        case (s.op)
            OP_PASS: v = c0;
            OP_LT: v = (c0 < s.thr) ? c0 : 0;
            OP_GT: v = (c0 > s.thr) ? c0 : 0;
            OP_ATLEAST: v = (c0 >= s.thr) ? c0 : 0;
            OP_ATMOST: v = (c0 <= s.thr) ? c0 : 0;
            OP_EQ: v = (c0 == s.thr) ? c0 : 0;
            OP_NE: v = (c0 != s.thr) ? c0 : 0;
            OP_ADD: v = (mc > CMAX - c0) ? CMAX : c0 + mc;
            OP_SUB: v = (c0 < mc) ? 0 : c0 - mc;
            OP_MUL: begin
                if (c0 == 0) v = 0;
                else v = (mc > CMAX / c0) ? CMAX : c0 * mc;
            end
            OP_DIV: v = (mc == 0) ? 0 : c0 / mc;
            OP_DIVROUND: begin
                if (mc == 0) v = 0;
                else if (c0 < mc) v = 1;
                else begin
                    rm = c0 % mc;
                    v = c0 / mc;
                    if (rm >= mc - rm) v++;
                end
            end
            OP_MOD: v = (mc == 0) ? 0 : c0 % mc;
            OP_UNION: v = 64'(n);
            OP_UNION_MIN, OP_ISECT_MIN: begin
                if (s.op == OP_UNION_MIN || n == s.nstreams) begin
                    v = cnt[0];
                    for (int i = 1; i < n; i++) if (cnt[i] < v) v = cnt[i];
                end
            end
            OP_UNION_MAX, OP_ISECT_MAX: begin
                if (s.op == OP_UNION_MAX || n == s.nstreams) begin
                    v = cnt[0];
                    for (int i = 1; i < n; i++) if (v < cnt[i]) v = cnt[i];
                end
            end
            OP_UNION_SUM, OP_ISECT_SUM: begin
                if (s.op == OP_UNION_SUM || n == s.nstreams) begin
                    for (int i = 0; i < n; i++) begin
                        v = v + cnt[i];
                        if (v > CMAX) v = CMAX;
                    end
                end
            end
            OP_ISECT: v = (n == s.nstreams) ? c0 : 0;
            OP_SUBTRACT: begin
                if (first == 0) begin
                    v = c0;
                    for (int i = 1; i < n; i++) begin
                        if (v > cnt[i]) v = v - cnt[i];
                        else begin
                            v = 0;
                            break;
                        end
                    end
                end
            end
            OP_DIFF: v = (n == 1 && first == 0) ? c0 : 0;
            OP_SYMDIFF: v = (n == 1) ? c0 : 0;
            default: v = 0;
        endcase
        s.pend = mask;
        r.out_key = key;
        r.out_value = v[31:0];
        r.emit = (v[31:0] != 0);
        r.refill_mask = mask;
        return STEP_RESULT;
    endfunction

    // requests are predicted twice: once here to steer generation, once on acceptance
    function automatic int add_request(input t_in_item it);
        t_out_item scratch;
        t_step st;
        st = merge_step(gen_st, it, scratch);
        req_q.push_back(it);
        return (st == STEP_IGNORED) ? 0 : 1;
    endfunction

    function automatic t_in_item make_req(input int sid, input logic [63:0] key,
                                          input logic [31:0] cnt, input bit ex);
        t_in_item it;
        it.stream_id = sid[2:0];
        it.key = key;
        it.count = cnt;
        it.exhausted = ex;
        return it;
    endfunction

    function automatic logic [31:0] rand_count();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(0, 20));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 6))
            0: return 64'd0;
            1: return 64'($urandom_range(1, 3));
            2: return 64'($urandom_range(0, 20));
            3: return 64'hFFFF_FFFF_FFFF_FFFF;
            4: return {32'd0, $urandom};
            5: return CMAX;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_cfg(input logic [1:0] idx, input logic [63:0] val);
        merge_config(gen_st, idx, val);
        merge_config(chk_st, idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || i_in_valid || result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // sender side
    always @(posedge i_clk) begin : drive_requests
        t_out_item r;
        bit take;
        int idle_pct;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take = i_in_valid && !o_in_stall;
            if (take) begin
                if (merge_step(chk_st, i_in_data, r) == STEP_RESULT) result_q.push_back(r);
                n_accepted++;
            end
            if (!i_in_valid || take) begin
                idle_pct = (n_accepted < 300) ? 18 : (n_accepted < 600) ? 52 : 0;
                if (cycles[7:6] == 2'b00) idle_pct = 0;
                if (req_q.size() != 0 && !hold_sender && $urandom_range(0, 99) >= idle_pct) begin
                    i_in_data <= req_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= 10)
                $display("result %s: expected %h, got %h", name, want, got);
        end
    endtask

    // receiver side
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        int stall_pct;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                want = result_q.pop_front();
                check_field("out_key", want.out_key, o_out_data.out_key);
                check_field("out_value", 64'(want.out_value), 64'(o_out_data.out_value));
                check_field("emit", 64'(want.emit), 64'(o_out_data.emit));
                check_field("refill_mask", 64'(want.refill_mask), 64'(o_out_data.refill_mask));
                check_field("done_res", 64'(want.done_res), 64'(o_out_data.done_res));
            end
        end
        stall_pct = (n_accepted < 300) ? 52 : (n_accepted < 600) ? 18 : 0;
        if (cycles[7:6] == 2'b01) stall_pct = 0;
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sorted_count_stream_merge_combiner_unit: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        logic [63:0] last_key[MAX_STREAMS];
        int left[MAX_STREAMS];
        logic [63:0] base;
        int n_live, sid, phase, sc_val, dummy;
        merge_reset(gen_st);
        merge_reset(chk_st);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: key and count extremes, a suppressed key, a tie, end of merge, ignored requests
        write_cfg(CFG_OPERATION, 64'(OP_PASS));
        write_cfg(CFG_STREAM_COUNT, 64'd3);
        dummy = add_request(make_req(5, 64'd7, 32'd7, 1'b0));
        dummy = add_request(make_req(0, '1, 32'hFFFF_FFFF, 1'b0));
        dummy = add_request(make_req(1, 64'd0, 32'd0, 1'b0));
        dummy = add_request(make_req(2, 64'd0, 32'd0, 1'b1));
        dummy = add_request(make_req(1, '1, 32'd5, 1'b0));
        dummy = add_request(make_req(0, 64'd0, 32'd1, 1'b1));
        dummy = add_request(make_req(1, 64'd0, 32'd1, 1'b1));
        dummy = add_request(make_req(1, 64'd3, 32'd3, 1'b0));
        wait_drained();
        write_cfg(CFG_OPERATION, 64'(OP_UNION_SUM));
        write_cfg(CFG_STREAM_COUNT, 64'd2);
        dummy = add_request(make_req(0, 64'd9, 32'hFFFF_FFFF, 1'b0));
        dummy = add_request(make_req(1, 64'd9, 32'hFFFF_FFFF, 1'b0));
        dummy = add_request(make_req(0, 64'd0, 32'd0, 1'b1));
        dummy = add_request(make_req(1, 64'd0, 32'd0, 1'b1));
        wait_drained();

        phase = 0;
        n_live = 0;
        while (n_live < 900) begin
            write_cfg(CFG_OPERATION, (phase < 32) ? 64'(phase) : 64'($urandom_range(0, 31)));
            write_cfg(CFG_THRESHOLD, rand_operand());
            write_cfg(CFG_MATH_CONST, rand_operand());
            case (phase % 5)
                0: sc_val = (phase / 5) % 2 == 0 ? 0 : 15;
                1: sc_val = 8;
                2: sc_val = 1;
                default: sc_val = $urandom_range(0, 15);
            endcase
            write_cfg(CFG_STREAM_COUNT, 64'(sc_val));
            case ($urandom_range(0, 3))
                0: base = 64'd0;
                1: base = 64'hFFFF_FFFF_FFFF_FFC0;
                default: base = {$urandom, $urandom};
            endcase
            for (int i = 0; i < MAX_STREAMS; i++) begin
                last_key[i] = base;
                left[i] = $urandom_range(0, 5);
            end
            while (gen_st.pend != 0) begin
                if (phase == 6 && req_q.size() == 6) begin
                    // let everything queued so far come out before carrying on
                    wait_drained();
                end
                if ($urandom_range(0, 9) == 0) begin
                    n_live += add_request(make_req($urandom_range(0, 7), {$urandom, $urandom},
                                                   $urandom, 1'($urandom_range(0, 1))));
                end else begin
                    do sid = $urandom_range(0, MAX_STREAMS - 1); while (!gen_st.pend[sid]);
                    if (left[sid] == 0) begin
                        n_live += add_request(make_req(sid, {$urandom, $urandom}, $urandom, 1'b1));
                    end else begin
                        last_key[sid] = last_key[sid] + 64'($urandom_range(0, 3));
                        left[sid]--;
                        n_live += add_request(make_req(sid, last_key[sid], rand_count(), 1'b0));
                    end
                end
            end
            // requests after the end of a merge are dropped
            if ($urandom_range(0, 3) == 0)
                dummy = add_request(make_req($urandom_range(0, 7), {$urandom, $urandom},
                                             $urandom, 1'b0));
            wait_drained();
            phase++;
        end

        wait_drained();
        if (n_errors == 0 && result_q.size() == 0) begin
            $display("sorted_count_stream_merge_combiner_unit: match");
        end else begin
            $display("sorted_count_stream_merge_combiner_unit: mismatch");
        end
        $finish;
    end

endmodule
